// ===== design/upd_pkg.sv =====
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_PLUS_AS_SPACE = 2'd0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  // One queue word: the decoded bytes of one input, slot 0 goes out first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            fin;
  } upd_word_t;

  typedef struct packed {
    phase_t phase;
  } front_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Valid only for hex digits; letters of either case map through the low nibble.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

endpackage

// ===== design/upd_front.sv =====
module upd_front
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_is_final,
  output logic        in_stall,
  input  logic        plus_as_space,
  input  logic        q_full,
  output logic        push,
  output upd_word_t   push_word,
  output front_stat_t stat
);

  phase_t          phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [2:0][7:0] y;
  logic [1:0]      n;
  logic [7:0]      mapped;
  logic            b_hex;
  logic            acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b_hex    = is_hex(in_byte);
  assign mapped   = (in_byte == CH_PLUS && plus_as_space) ? CH_SPACE : in_byte;

  always_comb begin
    y         = '0;
    n         = 2'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (b_hex) begin
          held_nxt  = in_byte;
          phase_nxt = PH_HELD;
        end else begin
          y[0] = CH_PERCENT;
          if (in_byte == CH_PERCENT) begin
            n         = 2'd1;
            phase_nxt = PH_PCT;
          end else begin
            y[1]      = mapped;
            n         = 2'd2;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        if (b_hex) begin
          y[0]      = {hex_val(held_r), hex_val(in_byte)};
          n         = 2'd1;
          phase_nxt = PH_IDLE;
          held_nxt  = 8'h00;
        end else begin
          y[0] = CH_PERCENT;
          y[1] = held_r;
          if (in_byte == CH_PERCENT) begin
            n         = 2'd2;
            phase_nxt = PH_PCT;
          end else begin
            y[2]      = mapped;
            n         = 2'd3;
            phase_nxt = PH_IDLE;
            held_nxt  = 8'h00;
          end
        end
      end
      default: begin
        if (in_byte == CH_PERCENT) begin
          phase_nxt = PH_PCT;
        end else begin
          y[0]      = mapped;
          n         = 2'd1;
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    // end of string flushes an open escape as it came
    if (in_is_final) begin
      if (phase_nxt == PH_PCT) begin
        y[n] = CH_PERCENT;
        n    = n + 2'd1;
      end else if (phase_nxt == PH_HELD) begin
        y[0] = CH_PERCENT;
        y[1] = held_nxt;
        n    = 2'd2;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end
  end

  assign push            = acc && (n != 2'd0);
  assign push_word.bytes = y;
  assign push_word.cnt   = n;
  assign push_word.fin   = in_is_final;
  assign stat.phase      = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== design/upd_queue.sv =====
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  upd_word_t push_word,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output upd_word_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  upd_word_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== design/upd_back.sv =====
module upd_back
  import upd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  upd_word_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_run_last,
  output logic      out_string_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       acc;

  assign out_valid      = !empty;
  assign last           = (idx_r == head.cnt - 2'd1);
  assign acc            = out_valid && !out_stall;
  assign pop            = acc && last;
  assign out_byte       = head.bytes[idx_r];
  assign out_run_last   = last;
  assign out_string_end = last && head.fin;

  always_comb begin
    idx_nxt = idx_r;
    if (acc) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== design/url_percent_decoder_top.sv =====
// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// input    | in_valid, in_stall, in_byte, in_is_final      | in
// result   | out_valid, out_stall, out_byte, out_run_last, | out
//          | out_string_end                                |
// config   | psel, penable, pwrite, paddr, pwdata, prdata, | in/out
//          | pready                                        |
//
// An input word is classified in the cycle it is accepted; it yields 0 to 3
// result words, emitted one per cycle from the head of the queue while
// out_stall is low, so a word holds the result port until all its bytes are out.
// The one-byte result port sets the sustained rate; the front keeps taking
// words until the QUEUE_DEPTH-word queue fills.
// Reset is synchronous, active low; it empties the queue, clears the escape
// state and sets plus_as_space to 0. Each side stalls on its own.
module url_percent_decoder_top
  import upd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4  // words, 2 or more
) (
  input  logic              clk,
  input  logic              rst_n,
  // input word
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_is_final,
  // result word
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_string_end,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic        plus_r;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  upd_word_t   q_in;
  upd_word_t   q_head;
  front_stat_t f_stat;

  // Single register: every address in the window maps to plus_as_space.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PLUS_AS_SPACE) ? {{(DATA_W-1){1'b0}}, plus_r} :
                                                 {{(DATA_W-1){1'b0}}, plus_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      plus_r <= pwdata[0];
    end
  end

  // Front: escape tracking, builds one queue word per input that yields bytes.
  upd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .in_is_final   (in_is_final),
    .in_stall      (in_stall),
    .plus_as_space (plus_r),
    .q_full        (q_full),
    .push          (q_push),
    .push_word     (q_in),
    .stat          (f_stat)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: serializes the head word onto the byte-wide result port.
  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  // string end only ever lands on the last byte of a run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last)
    else $error("string_end without run_last");

  // a final input always yields at least one byte
  a_final_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_final |-> q_push)
    else $error("final input produced no word");

  // escape state is idle after the end of a string
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_final |=> f_stat.phase == PH_IDLE)
    else $error("escape left open after final input");

  // a queued word never has an empty run
  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> q_head.cnt != 2'd0)
    else $error("empty word at queue head");

endmodule
